>>> src/assert_macros.svh
// Assertion macros used by the sentence ring buffer datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define NSRB_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define NSRB_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

`endif

>>> src/nsrb_pkg.sv
// Shared types and constants for the NMEA sentence ring buffer.
`default_nettype none

package nsrb_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic CMD_RECEIVE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  typedef enum logic [1:0] {
    KIND_RX_ACK = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_NONE   = 2'd2
  } kind_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic rx;          // receive beat accepted
    logic rd_empty;    // read beat accepted, ring empty
    logic rd_open;     // read beat accepted, fetch descriptor and free slot
    logic meta_none;   // descriptor shows empty slot
    logic meta_start;  // descriptor valid, start streaming
    logic issue;       // read next byte from byte memory
    logic move;        // fetch stage to output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic empty;       // no closed sentence waiting
    logic meta_zero;   // fetched descriptor has length zero
    logic more;        // bytes left to issue
    logic fetch_valid; // fetch stage holds a byte
    logic out_free;    // output register can load this cycle
  } status_t;

endpackage

`default_nettype wire

>>> src/nmea_sentence_ring_buffer.sv
// Top level of the NMEA sentence ring buffer.
`default_nettype none

// NMEA sentence ring buffer. Received bytes (cmd 0) are packed into a ring of
// SLOTS sentence slots of MSG_LEN bytes each; a '$' after stored bytes closes
// the slot and opens the next with the '$'. A byte that finds the slot full
// closes it with the error flag set, is dropped, and input is then skipped
// until a CR LF pair. With the ring full, received bytes are dropped. A read
// (cmd 1) returns the oldest closed sentence as one beat per byte, last byte
// flagged, and frees its slot; an empty ring answers with a single
// "no message" beat. Every input beat yields at least one result beat, and
// the final result of each input beat carries last.
// Timing: receive beats can stream at one per cycle while the output is
// drained. A read first reads the slot descriptor, then latches its length,
// then reads the first byte from the byte memory read port, and then moves
// one byte per cycle to the output register while the output is not stalled;
// the next input beat is held off until the read has finished. Output
// backpressure stalls the byte stream without loss. Storage is a
// SLOTS*MSG_LEN byte memory plus a SLOTS-entry descriptor memory written when
// a slot closes; neither needs clearing after reset, since only closed slots
// are ever read.
module nmea_sentence_ring_buffer #(
  parameter int MSG_LEN = 64,
  parameter int SLOTS   = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       cmd,
  input  wire logic [7:0] character,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      result_kind,
  output logic [7:0]      data_byte,
  output logic            message_error,
  output logic            last,
  output logic            char_dropped,
  output logic            ring_full
);

  nsrb_pkg::cmd_t    ctl;
  nsrb_pkg::status_t st;

  // Sequencer: handshake and readout steps.
  nsrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st),
    .ctl      (ctl)
  );

  // Slot storage, ring pointers, fetch stage and output register.
  nsrb_datapath #(
    .MSG_LEN (MSG_LEN),
    .SLOTS   (SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .st            (st),
    .character     (character),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_kind   (result_kind),
    .data_byte     (data_byte),
    .message_error (message_error),
    .last          (last),
    .char_dropped  (char_dropped),
    .ring_full     (ring_full)
  );

endmodule

`default_nettype wire

>>> src/nsrb_ctrl.sv
// Sequencing controller for the NMEA sentence ring buffer.
`default_nettype none

module nsrb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             cmd,
  input  wire nsrb_pkg::status_t st,
  output nsrb_pkg::cmd_t        ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_META,
    S_STREAM
  } state_t;

  state_t state;
  state_t state_next;
  logic   acc;

  assign in_ready = (state == S_IDLE) && st.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    ctl            = '0;
    state_next     = state;
    ctl.rx         = acc && (cmd == nsrb_pkg::CMD_RECEIVE);
    ctl.rd_empty   = acc && (cmd == nsrb_pkg::CMD_READ) && st.empty;
    ctl.rd_open    = acc && (cmd == nsrb_pkg::CMD_READ) && !st.empty;
    ctl.meta_none  = (state == S_META) && st.meta_zero;
    ctl.meta_start = (state == S_META) && !st.meta_zero;
    ctl.move       = (state == S_STREAM) && st.fetch_valid && st.out_free;
    ctl.issue      = (state == S_STREAM) && st.more && (!st.fetch_valid || st.out_free);
    case (state)
      S_IDLE: begin
        if (ctl.rd_open) state_next = S_META;
      end
      S_META: begin
        state_next = st.meta_zero ? S_IDLE : S_STREAM;
      end
      S_STREAM: begin
        if (!st.more && (!st.fetch_valid || st.out_free)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> src/nsrb_datapath.sv
// Storage, pointers and output register of the NMEA sentence ring buffer.
`default_nettype none
`include "assert_macros.svh"

module nsrb_datapath #(
  parameter int MSG_LEN = 64,
  parameter int SLOTS   = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire nsrb_pkg::cmd_t   ctl,
  output nsrb_pkg::status_t     st,
  input  wire logic [7:0]       character,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            result_kind,
  output logic [7:0]            data_byte,
  output logic                  message_error,
  output logic                  last,
  output logic                  char_dropped,
  output logic                  ring_full
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LEN_W  = $clog2(MSG_LEN + 1);
  localparam int IDX_W  = $clog2(MSG_LEN);
  localparam int DEPTH  = SLOTS * MSG_LEN;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef struct packed {
    logic             err;
    logic [LEN_W-1:0] len;
  } meta_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    n = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] s,
                                                input logic [IDX_W-1:0]  i);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(s) * ADDR_W'(MSG_LEN) + ADDR_W'(i);
    return a;
  endfunction

  // Memories
  logic [7:0] byte_mem [DEPTH];
  meta_t      meta_mem [SLOTS];

  // Ring control
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] wr_slot;
  logic              full;
  logic              skip;
  logic              last_cr;
  logic [LEN_W-1:0]  wr_len;

  // Readout
  logic [SLOT_W-1:0] base_slot;
  meta_t             meta_q;
  logic [LEN_W-1:0]  rd_len;
  logic [LEN_W-1:0]  rd_idx;
  logic              rd_err;
  logic [7:0]        fetch_byte;
  logic              fetch_valid;
  logic              fetch_last;

  // Receive decode
  logic              blocked;
  logic              is_dollar;
  logic              close_carry;
  logic              close_ovf;
  logic              do_store;
  logic              do_close;
  logic [SLOT_W-1:0] nxt_slot;
  logic              hits_rd;
  logic              dropped;
  logic              full_next;
  logic              bwr_en;
  logic [ADDR_W-1:0] bwr_addr;
  logic              out_free;

  assign blocked     = full || skip;
  assign is_dollar   = (character == nsrb_pkg::CH_DOLLAR);
  assign close_carry = ctl.rx && !blocked && is_dollar && (wr_len != '0);
  assign close_ovf   = ctl.rx && !blocked && !(is_dollar && (wr_len != '0))
                       && (wr_len >= LEN_W'(MSG_LEN));
  assign do_store    = ctl.rx && !blocked && !close_carry && !close_ovf;
  assign do_close    = close_carry || close_ovf;
  assign nxt_slot    = next_slot(wr_slot);
  assign hits_rd     = (nxt_slot == rd_slot);
  assign dropped     = blocked || close_ovf || (close_carry && hits_rd);
  assign full_next   = full || (do_close && hits_rd);

  // One byte write per cycle: the stored byte or the carried '$'.
  assign bwr_en   = do_store || (close_carry && !hits_rd);
  assign bwr_addr = do_store ? addr_of(wr_slot, wr_len[IDX_W-1:0])
                             : addr_of(nxt_slot, '0);

  assign out_free = !out_valid || out_ready;

  assign st.empty       = !full && (rd_slot == wr_slot);
  assign st.meta_zero   = (meta_q.len == '0);
  assign st.more        = (rd_idx != rd_len);
  assign st.fetch_valid = fetch_valid;
  assign st.out_free    = out_free;

  always_ff @(posedge clk) begin
    if (bwr_en) byte_mem[bwr_addr] <= character;
    if (do_close) meta_mem[wr_slot] <= '{err: close_ovf, len: wr_len};
    if (ctl.rd_open) meta_q <= meta_mem[rd_slot];
    if (ctl.issue) fetch_byte <= byte_mem[addr_of(base_slot, rd_idx[IDX_W-1:0])];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_slot     <= '0;
      wr_slot     <= '0;
      full        <= 1'b0;
      skip        <= 1'b0;
      last_cr     <= 1'b0;
      wr_len      <= '0;
      rd_len      <= '0;
      rd_idx      <= '0;
      fetch_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (ctl.rx) begin
        full    <= full_next;
        skip    <= (skip || close_ovf)
                   && !(last_cr && (character == nsrb_pkg::CH_LF));
        last_cr <= (character == nsrb_pkg::CH_CR);
        if (do_store) begin
          wr_len <= wr_len + 1'b1;
        end else if (do_close) begin
          wr_slot <= nxt_slot;
          if (!hits_rd) wr_len <= close_carry ? LEN_W'(1) : '0;
        end
      end
      if (ctl.rd_open) begin
        rd_slot   <= next_slot(rd_slot);
        base_slot <= rd_slot;
        full      <= 1'b0;
        // A full ring parks the write slot on the slot just freed.
        if (full) wr_len <= '0;
      end
      if (ctl.meta_start) begin
        rd_len <= meta_q.len;
        rd_err <= meta_q.err;
        rd_idx <= '0;
      end
      if (ctl.issue) begin
        rd_idx     <= rd_idx + 1'b1;
        fetch_last <= (rd_idx + 1'b1 == rd_len);
      end
      fetch_valid <= ctl.issue || (fetch_valid && !ctl.move);

      if (ctl.rx || ctl.rd_empty || ctl.meta_none || ctl.move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (ctl.rx) begin
      result_kind   <= nsrb_pkg::KIND_RX_ACK;
      data_byte     <= '0;
      message_error <= 1'b0;
      last          <= 1'b1;
      char_dropped  <= dropped;
      ring_full     <= full_next;
    end else if (ctl.rd_empty || ctl.meta_none) begin
      result_kind   <= nsrb_pkg::KIND_NONE;
      data_byte     <= '0;
      message_error <= 1'b0;
      last          <= 1'b1;
      char_dropped  <= 1'b0;
      ring_full     <= full;
    end else if (ctl.move) begin
      result_kind   <= nsrb_pkg::KIND_BYTE;
      data_byte     <= fetch_byte;
      message_error <= rd_err;
      last          <= fetch_last;
      char_dropped  <= 1'b0;
      ring_full     <= full;
    end
  end

  `NSRB_ASSERT(a_full_ptrs, !full || (rd_slot == wr_slot), "full ring with pointers apart")
  `NSRB_ASSERT(a_len_range, wr_len <= LEN_W'(MSG_LEN), "write length beyond slot size")
  `NSRB_ASSERT(a_issue_room, !ctl.issue || !fetch_valid || ctl.move, "fetch stage overrun")
  `NSRB_ASSERT_NEXT(a_rx_out, ctl.rx, out_valid && last, "receive beat produced no result")

endmodule

`default_nettype wire
